### sv/ctla_pkg.sv
package ctla_pkg;

    // Defaults for the top-level parameters
    localparam int COORD_WIDTH_DEF   = 24;
    localparam int CORDIC_STAGES_DEF = 20;

    // Normalisation: largest magnitude is brought into [2^28, 2^29)
    localparam int NORM_W     = 30;
    localparam int NORM_TOP   = 28;
    localparam int NORM_STEPS = 5;

    // Horizontal range: squares and the digit-by-digit root
    localparam int SQ_W       = 60;
    localparam int SQRT_STEPS = 30;
    localparam int ROOT_W     = 30;

    // CORDIC datapath and angle accumulator (degrees Q24)
    localparam int CX_W  = 34;
    localparam int ANG_W = 34;

    // Result fields
    localparam int AZ_W        = 25;
    localparam int EL_W        = 24;
    localparam int OUT_TDATA_W = 56;
    localparam int AZ_LIMIT    = 11796480;
    localparam int EL_LIMIT    = 5898240;
    localparam longint QUARTER_Q24 = 64'd1509949440;
    localparam logic [63:0] RAD2DEG_Q24 = 64'd961263669;

    typedef logic signed [CX_W-1:0]  cx_t;
    typedef logic signed [ANG_W-1:0] ang_t;

    typedef struct packed {
        logic                   valid_res;
        logic signed [AZ_W-1:0] azimuth;
        logic signed [EL_W-1:0] elevation;
    } res_t;

    // Restoring division, only ever evaluated while building constants
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] rem;
        int          b;
        q   = '0;
        rem = '0;
        for (b = 63; b >= 0; b--)
        begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den})
            begin
                rem  = rem - {1'b0, den};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // atan(2^-i) in degrees Q24: arctan series in radians Q60, cut to Q32, scaled
    function automatic logic [63:0] stage_angle(input int i);
        logic [63:0]        one_q60;
        logic [63:0]        term;
        logic [63:0]        q32;
        logic [63:0]        prod;
        logic signed [63:0] acc;
        int                 k;
        int                 sh;
        one_q60 = 64'd1 << 60;
        acc     = '0;
        if (i == 0)
        begin
            return 64'd45 << 24;
        end
        for (k = 0; k < 30; k++)
        begin
            sh = i * (2 * k + 1);
            if (sh < 60)
            begin
                term = udiv64(one_q60 >> sh, 64'(2 * k + 1));
                if (k[0])
                    acc = acc - signed'(term);
                else
                    acc = acc + signed'(term);
            end
        end
        q32  = unsigned'(acc) >> 28;
        prod = q32 * RAD2DEG_Q24 + (64'd1 << 31);
        return prod >> 32;
    endfunction

endpackage

### sv/cartesian_to_look_angles.sv
// Cartesian position to look angles (azimuth, elevation).
//
// Slave channel s_*: one transaction carries a target position x, y, z as
// signed coordinates. Master channel m_*: one transaction per input carries
// azimuth = atan2(y, x) and elevation = atan2(z, horizontal range), both in
// degrees * 65536; m_tuser is low when x = y = z = 0, and then both angles
// are zero.
//
// Throughput: one transaction per clock while s_tready is high. The pipeline
// runs through input, abs, max, five normalisation shifts, squaring, sum,
// thirty root digits, pre-rotation, the CORDIC stages, rounding and the
// output register.
//
// Reset clears every valid bit; nothing else needs clearing. When the
// receiver stalls, a finished result waits in the output register and the
// next one in a skid register; only once the skid register is full does
// s_tready drop and the whole pipeline hold, losing and repeating nothing.
module cartesian_to_look_angles #(
    parameter int COORD_WIDTH   = ctla_pkg::COORD_WIDTH_DEF,
    parameter int CORDIC_STAGES = ctla_pkg::CORDIC_STAGES_DEF
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        s_tvalid,
    output logic                                        s_tready,
    // pos_x, pos_y, pos_z (from bit 0 up), zero padded to bytes
    input  logic [((3 * COORD_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
    output logic                                        m_tvalid,
    input  logic                                        m_tready,
    // azimuth, elevation (from bit 0 up), zero padded to bytes
    output logic [ctla_pkg::OUT_TDATA_W-1:0]            m_tdata,
    // valid_res
    output logic                                        m_tuser
);
    import ctla_pkg::*;

    localparam int CW  = COORD_WIDTH;
    localparam int NW  = (CW > NORM_W) ? CW : NORM_W;
    localparam int PAD = OUT_TDATA_W - AZ_W - EL_W;

    localparam ang_t QUARTER = ANG_W'(QUARTER_Q24);
    localparam ang_t AZ_HI   = ANG_W'(AZ_LIMIT);
    localparam ang_t AZ_LO   = -AZ_HI;
    localparam ang_t EL_HI   = ANG_W'(EL_LIMIT);
    localparam ang_t EL_LO   = -EL_HI;
    localparam logic signed [AZ_W-1:0] AZ_MAX = AZ_W'(AZ_LIMIT);
    localparam logic signed [EL_W-1:0] EL_MAX = EL_W'(EL_LIMIT);

    // Global advance: the pipeline holds only while the skid register is full
    logic en;
    logic skid_valid_reg;

    assign en       = !skid_valid_reg;
    assign s_tready = en;

    // ------------------------------------------------------------------
    // Input capture, sign extended to the working width
    // ------------------------------------------------------------------
    logic                 in_v_reg;
    logic signed [NW-1:0] in_x_reg, in_y_reg, in_z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_v_reg <= 1'b0;
        else if (en)
            in_v_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            in_x_reg <= NW'($signed(s_tdata[CW-1:0]));
            in_y_reg <= NW'($signed(s_tdata[2*CW-1:CW]));
            in_z_reg <= NW'($signed(s_tdata[3*CW-1:2*CW]));
        end
    end

    // ------------------------------------------------------------------
    // Magnitudes and the all-zero flag
    // ------------------------------------------------------------------
    logic                 ab_v_reg, ab_zero_reg;
    logic signed [NW-1:0] ab_x_reg, ab_y_reg, ab_z_reg;
    logic        [NW-1:0] ab_mx_reg, ab_my_reg, ab_mz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ab_v_reg <= 1'b0;
        else if (en)
            ab_v_reg <= in_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ab_x_reg    <= in_x_reg;
            ab_y_reg    <= in_y_reg;
            ab_z_reg    <= in_z_reg;
            ab_mx_reg   <= unsigned'(in_x_reg[NW-1] ? -in_x_reg : in_x_reg);
            ab_my_reg   <= unsigned'(in_y_reg[NW-1] ? -in_y_reg : in_y_reg);
            ab_mz_reg   <= unsigned'(in_z_reg[NW-1] ? -in_z_reg : in_z_reg);
            ab_zero_reg <= (in_x_reg == '0) && (in_y_reg == '0) && (in_z_reg == '0);
        end
    end

    // ------------------------------------------------------------------
    // Largest magnitude (entry 0), then one normalising shift per stage
    // ------------------------------------------------------------------
    logic                 nm_v_reg    [0:NORM_STEPS];
    logic                 nm_zero_reg [0:NORM_STEPS];
    logic signed [NW-1:0] nm_x_reg    [0:NORM_STEPS];
    logic signed [NW-1:0] nm_y_reg    [0:NORM_STEPS];
    logic signed [NW-1:0] nm_z_reg    [0:NORM_STEPS];
    logic        [NW-1:0] nm_m_reg    [0:NORM_STEPS];
    logic        [NW-1:0] ab_mxy;

    assign ab_mxy = (ab_my_reg > ab_mx_reg) ? ab_my_reg : ab_mx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            nm_v_reg[0] <= 1'b0;
        else if (en)
            nm_v_reg[0] <= ab_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nm_x_reg[0]    <= ab_x_reg;
            nm_y_reg[0]    <= ab_y_reg;
            nm_z_reg[0]    <= ab_z_reg;
            nm_zero_reg[0] <= ab_zero_reg;
            nm_m_reg[0]    <= (ab_mz_reg > ab_mxy) ? ab_mz_reg : ab_mxy;
        end
    end

    for (genvar j = 0; j < NORM_STEPS; j++)
    begin : g_norm
        localparam int S = 1 << (NORM_STEPS - 1 - j);

        logic                 down, up;
        logic signed [NW-1:0] x_next, y_next, z_next;
        logic        [NW-1:0] m_next;

        // Shift right while too large (floor), left while too small
        always_comb
        begin
            down = (nm_m_reg[j] >> (NORM_TOP + S)) != '0;
            up   = (nm_m_reg[j] >> (NORM_TOP + 1 - S)) == '0;
            if (down)
            begin
                x_next = nm_x_reg[j] >>> S;
                y_next = nm_y_reg[j] >>> S;
                z_next = nm_z_reg[j] >>> S;
                m_next = nm_m_reg[j] >> S;
            end
            else if (up)
            begin
                x_next = nm_x_reg[j] <<< S;
                y_next = nm_y_reg[j] <<< S;
                z_next = nm_z_reg[j] <<< S;
                m_next = nm_m_reg[j] << S;
            end
            else
            begin
                x_next = nm_x_reg[j];
                y_next = nm_y_reg[j];
                z_next = nm_z_reg[j];
                m_next = nm_m_reg[j];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                nm_v_reg[j+1] <= 1'b0;
            else if (en)
                nm_v_reg[j+1] <= nm_v_reg[j];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                nm_x_reg[j+1]    <= x_next;
                nm_y_reg[j+1]    <= y_next;
                nm_z_reg[j+1]    <= z_next;
                nm_m_reg[j+1]    <= m_next;
                nm_zero_reg[j+1] <= nm_zero_reg[j];
            end
        end
    end

    // ------------------------------------------------------------------
    // Squares of the normalised x and y
    // ------------------------------------------------------------------
    logic signed [NORM_W-1:0] n_x, n_y, n_z;
    logic signed [SQ_W-1:0]   xx, yy;

    assign n_x = nm_x_reg[NORM_STEPS][NORM_W-1:0];
    assign n_y = nm_y_reg[NORM_STEPS][NORM_W-1:0];
    assign n_z = nm_z_reg[NORM_STEPS][NORM_W-1:0];
    assign xx  = n_x * n_x;
    assign yy  = n_y * n_y;

    logic                     sq_v_reg, sq_zero_reg;
    logic signed [NORM_W-1:0] sq_x_reg, sq_y_reg, sq_z_reg;
    logic        [SQ_W-1:0]   sq_xx_reg, sq_yy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sq_v_reg <= 1'b0;
        else if (en)
            sq_v_reg <= nm_v_reg[NORM_STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_x_reg    <= n_x;
            sq_y_reg    <= n_y;
            sq_z_reg    <= n_z;
            sq_zero_reg <= nm_zero_reg[NORM_STEPS];
            sq_xx_reg   <= unsigned'(xx);
            sq_yy_reg   <= unsigned'(yy);
        end
    end

    // ------------------------------------------------------------------
    // Horizontal range: sum of squares (entry 0), then one root digit a stage
    // ------------------------------------------------------------------
    logic                     rt_v_reg    [0:SQRT_STEPS];
    logic                     rt_zero_reg [0:SQRT_STEPS];
    logic signed [NORM_W-1:0] rt_x_reg    [0:SQRT_STEPS];
    logic signed [NORM_W-1:0] rt_y_reg    [0:SQRT_STEPS];
    logic signed [NORM_W-1:0] rt_z_reg    [0:SQRT_STEPS];
    logic        [SQ_W-1:0]   rt_n_reg    [0:SQRT_STEPS];
    logic        [SQ_W:0]     rt_r_reg    [0:SQRT_STEPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rt_v_reg[0] <= 1'b0;
        else if (en)
            rt_v_reg[0] <= sq_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rt_x_reg[0]    <= sq_x_reg;
            rt_y_reg[0]    <= sq_y_reg;
            rt_z_reg[0]    <= sq_z_reg;
            rt_zero_reg[0] <= sq_zero_reg;
            rt_n_reg[0]    <= sq_xx_reg + sq_yy_reg;
            rt_r_reg[0]    <= '0;
        end
    end

    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_root
        localparam logic [SQ_W:0] BIT = (SQ_W + 1)'(1) << (2 * (SQRT_STEPS - 1 - k));

        logic [SQ_W:0]   trial;
        logic            ge;
        logic [SQ_W-1:0] n_next;
        logic [SQ_W:0]   r_next;

        // Restoring square root digit
        always_comb
        begin
            trial = rt_r_reg[k] + BIT;
            ge    = {1'b0, rt_n_reg[k]} >= trial;
            if (ge)
            begin
                n_next = rt_n_reg[k] - trial[SQ_W-1:0];
                r_next = (rt_r_reg[k] >> 1) + BIT;
            end
            else
            begin
                n_next = rt_n_reg[k];
                r_next = rt_r_reg[k] >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                rt_v_reg[k+1] <= 1'b0;
            else if (en)
                rt_v_reg[k+1] <= rt_v_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rt_x_reg[k+1]    <= rt_x_reg[k];
                rt_y_reg[k+1]    <= rt_y_reg[k];
                rt_z_reg[k+1]    <= rt_z_reg[k];
                rt_zero_reg[k+1] <= rt_zero_reg[k];
                rt_n_reg[k+1]    <= n_next;
                rt_r_reg[k+1]    <= r_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // Pre-rotation into the right half plane (entry 0), then CORDIC stages
    // ------------------------------------------------------------------
    logic cd_v_reg    [0:CORDIC_STAGES];
    logic cd_zero_reg [0:CORDIC_STAGES];
    logic cd_azz_reg  [0:CORDIC_STAGES];
    cx_t  cd_ax_reg   [0:CORDIC_STAGES];
    cx_t  cd_ay_reg   [0:CORDIC_STAGES];
    ang_t cd_aa_reg   [0:CORDIC_STAGES];
    cx_t  cd_ex_reg   [0:CORDIC_STAGES];
    cx_t  cd_ey_reg   [0:CORDIC_STAGES];
    ang_t cd_ea_reg   [0:CORDIC_STAGES];

    cx_t  pr_x, pr_y;
    cx_t  ax_next, ay_next;
    ang_t aa_next;

    assign pr_x = CX_W'(rt_x_reg[SQRT_STEPS]);
    assign pr_y = CX_W'(rt_y_reg[SQRT_STEPS]);

    always_comb
    begin
        priority if (pr_x < 0 && pr_y >= 0)
        begin
            ax_next = pr_y;
            ay_next = -pr_x;
            aa_next = QUARTER;
        end
        else if (pr_x < 0)
        begin
            ax_next = -pr_y;
            ay_next = pr_x;
            aa_next = -QUARTER;
        end
        else
        begin
            ax_next = pr_x;
            ay_next = pr_y;
            aa_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cd_v_reg[0] <= 1'b0;
        else if (en)
            cd_v_reg[0] <= rt_v_reg[SQRT_STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cd_zero_reg[0] <= rt_zero_reg[SQRT_STEPS];
            cd_azz_reg[0]  <= (pr_x == '0) && (pr_y == '0);
            cd_ax_reg[0]   <= ax_next;
            cd_ay_reg[0]   <= ay_next;
            cd_aa_reg[0]   <= aa_next;
            cd_ex_reg[0]   <= CX_W'(rt_r_reg[SQRT_STEPS][ROOT_W-1:0]);
            cd_ey_reg[0]   <= CX_W'(rt_z_reg[SQRT_STEPS]);
            cd_ea_reg[0]   <= '0;
        end
    end

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_cordic
        localparam ang_t ANGLE = ANG_W'(stage_angle(i));

        cx_t  ax_step, ay_step, ex_step, ey_step;
        ang_t aa_step, ea_step;

        // Vectoring micro-rotation, azimuth and elevation side by side
        always_comb
        begin
            if (cd_ay_reg[i] >= 0)
            begin
                ax_step = cd_ax_reg[i] + (cd_ay_reg[i] >>> i);
                ay_step = cd_ay_reg[i] - (cd_ax_reg[i] >>> i);
                aa_step = cd_aa_reg[i] + ANGLE;
            end
            else
            begin
                ax_step = cd_ax_reg[i] - (cd_ay_reg[i] >>> i);
                ay_step = cd_ay_reg[i] + (cd_ax_reg[i] >>> i);
                aa_step = cd_aa_reg[i] - ANGLE;
            end
            if (cd_ey_reg[i] >= 0)
            begin
                ex_step = cd_ex_reg[i] + (cd_ey_reg[i] >>> i);
                ey_step = cd_ey_reg[i] - (cd_ex_reg[i] >>> i);
                ea_step = cd_ea_reg[i] + ANGLE;
            end
            else
            begin
                ex_step = cd_ex_reg[i] - (cd_ey_reg[i] >>> i);
                ey_step = cd_ey_reg[i] + (cd_ex_reg[i] >>> i);
                ea_step = cd_ea_reg[i] - ANGLE;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                cd_v_reg[i+1] <= 1'b0;
            else if (en)
                cd_v_reg[i+1] <= cd_v_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                cd_zero_reg[i+1] <= cd_zero_reg[i];
                cd_azz_reg[i+1]  <= cd_azz_reg[i];
                cd_ax_reg[i+1]   <= ax_step;
                cd_ay_reg[i+1]   <= ay_step;
                cd_aa_reg[i+1]   <= aa_step;
                cd_ex_reg[i+1]   <= ex_step;
                cd_ey_reg[i+1]   <= ey_step;
                cd_ea_reg[i+1]   <= ea_step;
            end
        end
    end

    // ------------------------------------------------------------------
    // Round Q24 to Q16 (ties upward), saturate, apply the zero cases
    // ------------------------------------------------------------------
    ang_t az_round, el_round, az_sat, el_sat;
    res_t fin_next;

    always_comb
    begin
        az_round = (cd_aa_reg[CORDIC_STAGES] + ANG_W'(128)) >>> 8;
        el_round = (cd_ea_reg[CORDIC_STAGES] + ANG_W'(128)) >>> 8;
        priority if (az_round > AZ_HI)
            az_sat = AZ_HI;
        else if (az_round < AZ_LO)
            az_sat = AZ_LO;
        else
            az_sat = az_round;
        priority if (el_round > EL_HI)
            el_sat = EL_HI;
        else if (el_round < EL_LO)
            el_sat = EL_LO;
        else
            el_sat = el_round;

        fin_next.valid_res = !cd_zero_reg[CORDIC_STAGES];
        fin_next.azimuth   = (cd_zero_reg[CORDIC_STAGES] || cd_azz_reg[CORDIC_STAGES])
                           ? '0 : az_sat[AZ_W-1:0];
        fin_next.elevation = cd_zero_reg[CORDIC_STAGES] ? '0 : el_sat[EL_W-1:0];
    end

    logic fin_v_reg;
    res_t fin_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fin_v_reg <= 1'b0;
        else if (en)
            fin_v_reg <= cd_v_reg[CORDIC_STAGES];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            fin_reg <= fin_next;
    end

    // ------------------------------------------------------------------
    // Output register with skid register behind it
    // ------------------------------------------------------------------
    logic out_valid_reg, out_valid_next;
    logic skid_valid_next;
    res_t out_reg, out_next;
    res_t skid_reg, skid_next;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (!out_valid_reg || m_tready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = fin_v_reg;
                out_next       = fin_reg;
            end
        end
        else if (en && fin_v_reg)
        begin
            skid_valid_next = 1'b1;
            skid_next       = fin_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.valid_res;
    assign m_tdata  = {{PAD{1'b0}}, out_reg.elevation, out_reg.azimuth};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds a result while the output is empty");

    a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !m_tready))
        else $error("skid register filled without an output stall");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |=> $stable(fin_v_reg) && $stable(cd_v_reg[0]))
        else $error("pipeline moved while held");

    a_zero_range: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("zero range result carries nonzero angles");

    a_angle_limits: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (out_reg.azimuth <= AZ_MAX) && (out_reg.azimuth >= -AZ_MAX)
                  && (out_reg.elevation <= EL_MAX) && (out_reg.elevation >= -EL_MAX))
        else $error("angle beyond its saturation limit");

endmodule
